@@ rtl/bhpq_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bhpq_pkg
// Shared types and constants of the binary heap priority queue: request and
// response payloads, operation and status codes, default geometry.
// ---------------------------------------------------------------------------
package bhpq_pkg;

	// fixed field widths of the ports
	localparam int KEY_W  = 32;
	localparam int TAG_W  = 16;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 9;

	// default geometry
	localparam int DEF_CAPACITY = 256;
	localparam int DEF_KEY_BITS = 32;
	localparam int DEF_TAG_BITS = 16;

	// operation codes
	localparam logic ACT_INSERT  = 1'b0;
	localparam logic ACT_EXTRACT = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]  out_key;
		logic [TAG_W-1:0]  out_tag;
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
	} rsp_t;

endpackage
`default_nettype wire

@@ rtl/bhpq_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bhpq_ram
// Heap storage: one write port and two read ports, read data registered.
// Contents are undefined until written.
// ---------------------------------------------------------------------------
module bhpq_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 48,
	parameter int AW    = 8
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr0,
	input  wire logic [AW-1:0]    raddr1,
	output logic      [WIDTH-1:0] rdata0,
	output logic      [WIDTH-1:0] rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule
`default_nettype wire

@@ rtl/bhpq_seq.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bhpq_seq
// Heap sequencer: takes one request at a time, walks the heap one level per
// read/compare/write pair and hands one response to the output stage.
// The moving entry is held in a register; each level either moves the
// compared neighbor into the hole or drops the held entry there.
// ---------------------------------------------------------------------------
module bhpq_seq #(
	parameter int CAPACITY = 256,
	parameter int KEY_BITS = 32,
	parameter int TAG_BITS = 16,
	parameter int AW       = 8,
	parameter int EW       = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bhpq_pkg::req_t req,
	input  wire logic          req_valid,
	output logic               req_ready,
	output bhpq_pkg::rsp_t     res,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic [EW-1:0]      wdata,
	output logic [AW-1:0]      raddr0,
	output logic [AW-1:0]      raddr1,
	input  wire logic [EW-1:0] rdata0,
	input  wire logic [EW-1:0] rdata1
);
	import bhpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_UPCMP,
		S_XWAIT,
		S_DN,
		S_DNCMP,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         idx_q;
	logic [CW-1:0]         cnt_q;
	logic [EW-1:0]         x_q;
	logic [KEY_BITS-1:0]   res_key_q;
	logic [TAG_BITS-1:0]   res_tag_q;
	logic [STAT_W-1:0]     status_q;

	logic                  accept;
	logic [EW-1:0]         ent_in;
	logic [AW-1:0]         idx_m1;
	logic [AW-1:0]         pidx;
	logic [XW-1:0]         lc;
	logic [XW-1:0]         rc;
	logic                  l_ok;
	logic                  r_ok;
	logic                  pick_r;
	logic [EW-1:0]         best;
	logic [AW-1:0]         bidx;
	logic                  up_move;
	logic                  dn_move;
	logic                  full;
	logic                  empty;
	logic [CW-1:0]         cnt_m1;

	// request decode, entry ordered as {key, tag} so one compare decides
	assign accept = req_valid && req_ready;
	assign ent_in = {KEY_BITS'(req.key), TAG_BITS'(req.tag)};
	assign full   = (cnt_q == CW'(CAPACITY));
	assign empty  = (cnt_q == '0);
	assign cnt_m1 = cnt_q - CW'(1);

	// neighbor indexes of the hole
	assign idx_m1 = idx_q - AW'(1);
	assign pidx   = idx_m1 >> 1;
	assign lc     = XW'({idx_q, 1'b1});
	assign rc     = lc + XW'(1);
	assign l_ok   = (lc < XW'(cnt_q));
	assign r_ok   = (rc < XW'(cnt_q));

	// level decisions
	assign up_move = (x_q < rdata0);
	assign pick_r  = r_ok && (rdata1 < rdata0);
	assign best    = pick_r ? rdata1 : rdata0;
	assign bidx    = pick_r ? rc[AW-1:0] : lc[AW-1:0];
	assign dn_move = (best < x_q);

	// handshake and response
	assign req_ready     = (state_q == S_IDLE);
	assign res_valid     = (state_q == S_DONE);
	assign res.out_key   = KEY_W'(res_key_q);
	assign res.out_tag   = TAG_W'(res_tag_q);
	assign res.status    = status_q;
	assign res.count     = CNT_W'(cnt_q);

	// memory port control
	always_comb begin
		we     = 1'b0;
		waddr  = idx_q;
		wdata  = x_q;
		raddr0 = '0;
		raddr1 = AW'(cnt_m1);
		unique case (state_q)
			S_UP: begin
				raddr0 = pidx;
				we     = (idx_q == '0);
			end
			S_UPCMP: begin
				we    = 1'b1;
				wdata = up_move ? rdata0 : x_q;
			end
			S_DN: begin
				raddr0 = lc[AW-1:0];
				raddr1 = rc[AW-1:0];
				we     = !l_ok;
			end
			S_DNCMP: begin
				we    = 1'b1;
				wdata = dn_move ? best : x_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			x_q       <= '0;
			res_key_q <= '0;
			res_tag_q <= '0;
			status_q  <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_key_q <= '0;
						res_tag_q <= '0;
						status_q  <= ST_OK;
						if (req.action == ACT_INSERT) begin
							if (full) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								x_q     <= ent_in;
								idx_q   <= AW'(cnt_q);
								cnt_q   <= cnt_q + CW'(1);
								state_q <= S_UP;
							end
						end else begin
							if (empty) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								cnt_q   <= cnt_m1;
								state_q <= S_XWAIT;
							end
						end
					end
				end
				S_UP: begin
					state_q <= (idx_q == '0) ? S_DONE : S_UPCMP;
				end
				S_UPCMP: begin
					if (up_move) begin
						idx_q   <= pidx;
						state_q <= S_UP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_XWAIT: begin
					// root leaves, last entry becomes the held entry at the root
					res_key_q <= rdata0[EW-1:TAG_BITS];
					res_tag_q <= rdata0[TAG_BITS-1:0];
					x_q       <= rdata1;
					idx_q     <= '0;
					state_q   <= empty ? S_DONE : S_DN;
				end
				S_DN: begin
					state_q <= l_ok ? S_DNCMP : S_DONE;
				end
				S_DNCMP: begin
					if (dn_move) begin
						idx_q   <= bidx;
						state_q <= S_DN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/binary_heap_priority_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// binary_heap_priority_queue
// Min-heap ready queue of {key, tag} entries, smaller key first, ties to
// the smaller tag.
// Request channel (req_valid/req_ready, payload req): action 0 inserts the
// entry, action 1 extracts the top entry. Response channel (rsp_valid/
// rsp_ready, payload rsp): exactly one response per request, in order, with
// the extracted entry (zero otherwise), a status (ok, extract from empty,
// insert into full dropped) and the entry count after the operation.
// One request is worked at a time. An insert climbs from the first free slot
// toward the root; an extract returns the root and lets the last entry
// descend from the root toward the leaves. Each level is one read of the heap
// memory, a compare and a write back. The response sits in an output
// register behind the sequencer, so a new request is taken while an
// earlier response waits on a stalled receiver; the sequencer only waits when
// its own finished response finds that register still full.
// Reset empties the queue at once; memory contents are not cleared.
// ---------------------------------------------------------------------------
module binary_heap_priority_queue #(
	parameter int CAPACITY = bhpq_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = bhpq_pkg::DEF_KEY_BITS,
	parameter int TAG_BITS = bhpq_pkg::DEF_TAG_BITS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire bhpq_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output bhpq_pkg::rsp_t      rsp
);
	import bhpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int EW = KEY_BITS + TAG_BITS;

	rsp_t          res;
	logic          res_valid;
	logic          res_ready;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [AW-1:0] raddr0;
	logic [AW-1:0] raddr1;
	logic [EW-1:0] rdata0;
	logic [EW-1:0] rdata1;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	bhpq_seq #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS),
		.TAG_BITS(TAG_BITS),
		.AW      (AW),
		.EW      (EW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.res      (res),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr0   (raddr0),
		.raddr1   (raddr1),
		.rdata0   (rdata0),
		.rdata1   (rdata1)
	);

	bhpq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(EW),
		.AW   (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	// output register, refilled when empty or being drained
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// failed operations carry no entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |-> (rsp.out_key == '0 && rsp.out_tag == '0))
		else $error("failed operation returned a nonzero entry");

	// dropped insert only when the queue is at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |-> (rsp.count == CNT_W'(CAPACITY)))
		else $error("full status with count below capacity");

	// empty extract leaves count at zero
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_EMPTY) |-> (rsp.count == '0))
		else $error("empty status with nonzero count");

	// no request taken while a finished response is blocked in the sequencer
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> !(req_valid && req_ready))
		else $error("request accepted while response pending in sequencer");

endmodule
`default_nettype wire

@@ verif/binary_heap_priority_queue_tb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// binary_heap_priority_queue_tb
// Self-checking bench for the heap ready queue. A driver sends insert and
// extract requests from a backlog built at time zero, with random gaps, drain
// pauses and forced fill/drain phases that reach the full and empty corners.
// A monitor takes responses with random stalls and long hold-offs, and checks
// each one against an in-bench min-heap that tracks the queue contents.
// ---------------------------------------------------------------------------
module binary_heap_priority_queue_tb;
	import bhpq_pkg::*;

	localparam int CAP         = DEF_CAPACITY;
	localparam int ITEM_GOAL   = 1300;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 30;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} slot_t;

	typedef struct {
		req_t r;
		int   gap;
		bit   sync;
	} backlog_t;

	typedef enum logic [1:0] {PH_MIX, PH_FILL, PH_DRAIN} phase_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// shadow heap of the queue contents
	slot_t pq_slot [CAP];
	int    pq_fill = 0;

	backlog_t req_backlog_q [$];
	rsp_t     due_rsp_q [$];

	// generator bookkeeping
	int gen_fill     = 0;
	int gen_items    = 0;
	bit sync_pending = 1'b0;

	int mism_cnt     = 0;
	int wait_left    = 0;
	int quiet_cycles = 0;

	binary_heap_priority_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// a precedes b: smaller key, ties to smaller tag
	function automatic bit served_first(slot_t a, slot_t b);
		if (a.key != b.key)
			return a.key < b.key;
		return a.tag < b.tag;
	endfunction

	// apply one request to the shadow heap and build its response
	function automatic rsp_t pq_apply(req_t r);
		rsp_t  res;
		slot_t tmp;
		int    i;
		int    up;
		int    best;
		int    lc;
		int    rc;
		res = '0;
		res.status = ST_OK;
		if (r.action == ACT_INSERT) begin
			if (pq_fill >= CAP) begin
				res.status = ST_FULL;
			end else begin
				i = pq_fill;
				pq_slot[i] = '{key: r.key, tag: r.tag};
				pq_fill++;
				// sift up
				while (i > 0) begin
					up = (i - 1) / 2;
					if (!served_first(pq_slot[i], pq_slot[up]))
						break;
					tmp = pq_slot[i];
					pq_slot[i] = pq_slot[up];
					pq_slot[up] = tmp;
					i = up;
				end
			end
		end else if (pq_fill == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.out_key = pq_slot[0].key;
			res.out_tag = pq_slot[0].tag;
			pq_fill--;
			if (pq_fill > 0) begin
				pq_slot[0] = pq_slot[pq_fill];
				i = 0;
				// sift down
				forever begin
					best = i;
					lc = 2 * i + 1;
					rc = 2 * i + 2;
					if (lc < pq_fill && served_first(pq_slot[lc], pq_slot[best]))
						best = lc;
					if (rc < pq_fill && served_first(pq_slot[rc], pq_slot[best]))
						best = rc;
					if (best == i)
						break;
					tmp = pq_slot[i];
					pq_slot[i] = pq_slot[best];
					pq_slot[best] = tmp;
					i = best;
				end
			end
		end
		res.count = pq_fill[CNT_W-1:0];
		return res;
	endfunction

	// queue one request; a pending drain pause attaches to it
	task automatic add_item(logic act, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, int gap);
		backlog_t b;
		b.r.action = act;
		b.r.key    = k;
		b.r.tag    = t;
		b.gap      = gap;
		b.sync     = sync_pending;
		sync_pending = 1'b0;
		req_backlog_q.push_back(b);
		gen_items++;
		if (act == ACT_INSERT && gen_fill < CAP)
			gen_fill++;
		else if (act == ACT_EXTRACT && gen_fill > 0)
			gen_fill--;
	endtask

	// keys lean toward small values and extremes so ties are common
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return KEY_W'($urandom_range(0, 15));
			2: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return {1'b1, {(KEY_W-1){1'b0}}};
					default: return {1'b0, {(KEY_W-1){1'b1}}};
				endcase
			end
			default: return KEY_W'($urandom_range(0, 1000));
		endcase
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		case ($urandom_range(0, 2))
			0: return TAG_W'($urandom_range(0, 65535));
			1: return TAG_W'($urandom_range(0, 3));
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	task automatic add_random(logic act, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 9);
		if (act == ACT_INSERT)
			add_item(act, pick_key(), pick_tag(), gap);
		else
			add_item(act, $urandom, TAG_W'($urandom_range(0, 65535)), gap);
	endtask

	// stimulus: directed corners, then random phases
	initial begin
		phase_t ph;
		int     n_phase;
		int     len;
		int     pct;
		bit     no_gap;
		n_phase = 0;

		// extract from empty, extremes, equal keys with tie-breaking tags
		add_item(ACT_EXTRACT, '1, '1, $urandom_range(0, 9));
		add_item(ACT_INSERT, '1, '1, $urandom_range(0, 9));
		add_item(ACT_INSERT, '0, '1, $urandom_range(0, 9));
		add_item(ACT_INSERT, '0, '0, $urandom_range(0, 9));
		add_item(ACT_INSERT, '1, '0, $urandom_range(0, 9));
		add_item(ACT_INSERT, 32'd5, 16'd7, $urandom_range(0, 9));
		add_item(ACT_INSERT, 32'd5, 16'd3, $urandom_range(0, 9));
		add_item(ACT_INSERT, 32'd5, 16'd7, $urandom_range(0, 9));
		add_item(ACT_INSERT, 32'h8000_0000, 16'h8000, $urandom_range(0, 9));
		add_item(ACT_INSERT, 32'h7fff_ffff, 16'h7fff, $urandom_range(0, 9));
		repeat (10)
			add_item(ACT_EXTRACT, $urandom, TAG_W'($urandom_range(0, 65535)), 0);

		// first a full fill and a full drain, then random phases
		while (gen_items < ITEM_GOAL) begin
			if (n_phase == 0)
				ph = PH_FILL;
			else if (n_phase == 1)
				ph = PH_DRAIN;
			else if ($urandom_range(0, 5) < 4)
				ph = PH_MIX;
			else
				ph = $urandom_range(0, 1) ? PH_FILL : PH_DRAIN;
			no_gap = ($urandom_range(0, 3) == 0);
			sync_pending = (n_phase == 0) || ($urandom_range(0, 4) == 0);
			n_phase++;
			case (ph)
				PH_FILL: begin
					while (gen_fill < CAP)
						add_random(ACT_INSERT, no_gap);
					repeat ($urandom_range(1, 4))
						add_random(ACT_INSERT, no_gap);
				end
				PH_DRAIN: begin
					while (gen_fill > 0)
						add_random(ACT_EXTRACT, no_gap);
					repeat ($urandom_range(1, 3))
						add_random(ACT_EXTRACT, no_gap);
				end
				default: begin
					len = $urandom_range(30, 120);
					pct = $urandom_range(25, 75);
					repeat (len)
						add_random(($urandom_range(0, 99) < pct) ? ACT_INSERT : ACT_EXTRACT,
							no_gap);
				end
			endcase
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every request to go out and every response to come back
		while (req_backlog_q.size() != 0 || req_valid || due_rsp_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mism_cnt == 0 && due_rsp_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin : req_drive
		logic fire;
		int   wl;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			wait_left <= 0;
		end else begin
			fire = req_valid && req_ready;
			wl = wait_left;
			if (fire) begin
				due_rsp_q.push_back(pq_apply(req));
				if (req_backlog_q.size() > 0)
					wl = req_backlog_q[0].gap;
			end
			if (req_valid && !fire) begin
				// hold the offered request
			end else if (wl > 0) begin
				wl--;
				req_valid <= 1'b0;
			end else if (req_backlog_q.size() > 0 &&
					(!req_backlog_q[0].sync || due_rsp_q.size() == 0)) begin
				req       <= req_backlog_q[0].r;
				req_valid <= 1'b1;
				req_backlog_q.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
			wait_left <= wl;
		end
	end

	// response monitor with random stalls and periodic long hold-offs
	always @(posedge clk or negedge arst_n) begin : rsp_check
		rsp_t     want;
		logic     bad;
		int       stall_left;
		int       hold_left;
		int       n_rsp;
		bit       no_stall;
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
			n_rsp      = 0;
			no_stall   = 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				n_rsp++;
				if (due_rsp_q.size() == 0) begin
					mism_cnt++;
					if (mism_cnt <= 10)
						$display("unexpected response: key=%h tag=%h status=%0d count=%0d",
							rsp.out_key, rsp.out_tag, rsp.status, rsp.count);
				end else begin
					want = due_rsp_q.pop_front();
					bad = (rsp.out_key !== want.out_key) ||
						(rsp.out_tag !== want.out_tag) ||
						(rsp.status !== want.status) || (rsp.count !== want.count);
					if (bad) begin
						mism_cnt++;
						if (mism_cnt <= 10) begin
							$display("response %0d exp key=%h tag=%h status=%0d count=%0d",
								n_rsp, want.out_key, want.out_tag, want.status, want.count);
							$display("  got key=%h tag=%h status=%0d count=%0d",
								rsp.out_key, rsp.out_tag, rsp.status, rsp.count);
						end
					end
				end
				if (n_rsp % 128 == 0)
					no_stall = ($urandom_range(0, 3) == 0);
				stall_left = no_stall ? 0 : $urandom_range(0, 9);
				// long hold so the block backs up into the request side
				if (n_rsp % 400 == 300)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
`default_nettype wire
